@@ rtl/lcmt_pkg.sv @@
// shared constants, types and codes for the line tree block
`default_nettype none
package lcmt_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int NODE_COUNT = 4096;
  localparam int ADDR_W     = $clog2(NODE_COUNT);
  localparam int NIDX_W     = ADDR_W + 2;
  localparam int X_W        = $clog2(MAX_POINTS);
  localparam int DOM_W      = 11;
  localparam int SLOPE_W    = 32;
  localparam int ICPT_W     = 48;
  localparam int VAL_W      = 50;
  localparam int LINE_W     = 1 + SLOPE_W + ICPT_W;
  localparam int STK_DEPTH  = 16;
  localparam int STK_W      = $clog2(STK_DEPTH);

  typedef enum logic [1:0] {
    OP_FULL  = 2'd0,
    OP_SEG   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_DRD,
    S_DEV,
    S_DDEC,
    S_NEXT,
    S_CVIS,
    S_QRD,
    S_QEV,
    S_QACC,
    S_QOUT
  } state_t;

  typedef struct packed {
    logic [NIDX_W-1:0] idx;
    logic [X_W-1:0]    lo;
    logic [X_W-1:0]    hi;
  } cov_entry_t;

endpackage
`default_nettype wire

@@ rtl/li_chao_max_line_tree.sv @@
// top level: line tree store, sequencer and configuration port
// A Li Chao tree holding lines over x points 0 to domain_size-1, answering the
// maximum of the stored lines at a point. After reset the node store is cleared
// one node a cycle while in_stall stays high. Each item is then worked on alone
// and in_stall is high until it finishes. A query reads, evaluates and
// accumulates at each tree level; an add reads and evaluates each node visited
// in its descents and steps through each node of the segment split. The cost
// is set by the one line evaluator (one multiply-add a cycle) and the single
// read port of the node memory. A query result waits in an output register
// while new items are taken.
`default_nettype none
module li_chao_max_line_tree (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [1:0]                          in_op,
  input  wire logic signed [lcmt_pkg::SLOPE_W-1:0] in_slope,
  input  wire logic signed [lcmt_pkg::ICPT_W-1:0]  in_intercept,
  input  wire logic [lcmt_pkg::X_W-1:0]            in_seg_lo,
  input  wire logic [lcmt_pkg::X_W-1:0]            in_seg_hi,
  input  wire logic [lcmt_pkg::X_W-1:0]            in_query_x,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [lcmt_pkg::VAL_W-1:0]        out_max_value,
  output logic                                     out_found,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [1:0]                          paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);

  localparam int XW = lcmt_pkg::X_W;
  localparam int NW = lcmt_pkg::NIDX_W;
  localparam int AW = lcmt_pkg::ADDR_W;
  localparam int VW = lcmt_pkg::VAL_W;
  localparam int SW = lcmt_pkg::SLOPE_W;
  localparam int BW = lcmt_pkg::ICPT_W;
  localparam int LW = lcmt_pkg::LINE_W;
  localparam int STK_IDX = lcmt_pkg::STK_W;

  lcmt_pkg::state_t state_r, state_nxt;

  logic [lcmt_pkg::DOM_W-1:0] domain_r;
  logic signed [SW-1:0]       k_r, k_nxt;
  logic signed [BW-1:0]       b_r, b_nxt;
  logic signed [SW-1:0]       ks_r, ks_nxt;
  logic signed [BW-1:0]       bs_r, bs_nxt;
  logic [XW-1:0]              x_r, x_nxt;
  logic [XW-1:0]              lo_r, lo_nxt;
  logic [XW-1:0]              hi_r, hi_nxt;
  logic [NW-1:0]              i_r, i_nxt;
  logic [XW-1:0]              l_r, l_nxt;
  logic [XW-1:0]              r_r, r_nxt;
  logic [2:0]                 step_r, step_nxt;
  logic signed [VW-1:0]       best_r, best_nxt;
  logic                       found_r, found_nxt;
  logic [AW-1:0]              clr_r, clr_nxt;
  logic [lcmt_pkg::STK_W:0]   sp_r, sp_nxt;
  lcmt_pkg::cov_entry_t       stk_r [lcmt_pkg::STK_DEPTH];
  logic                       push, pop;
  lcmt_pkg::cov_entry_t       push_ent, top_ent;
  logic signed [VW-1:0]       res_r [6];
  logic                       res_we;

  logic                       out_valid_r, out_load;
  logic signed [VW-1:0]       out_value_r;
  logic                       out_found_r;

  logic                       in_acc, cfg_wr;
  logic [XW-1:0]              nm1, hi_clamp, mid;
  logic [XW:0]                lr_sum;
  logic [NW-1:0]              i_left, i_right;
  logic                       i_oob;

  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr;
  logic [LW-1:0]              ram_wdata, ram_rdata;
  logic                       rd_valid;
  logic signed [SW-1:0]       rd_slope;
  logic signed [BW-1:0]       rd_icpt;

  logic signed [SW-1:0]       ev_k;
  logic signed [BW-1:0]       ev_b;
  logic [XW-1:0]              ev_x;
  logic signed [VW-1:0]       ev_val;

  logic                       keep, repl, swapped, go_right;
  logic                       cvis_skip, cvis_full, drd_skip;

  lcmt_ram #(
    .WIDTH(LW),
    .DEPTH(lcmt_pkg::NODE_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(i_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  lcmt_eval u_eval (
    .clk  (clk),
    .slope(ev_k),
    .icpt (ev_b),
    .x    (ev_x),
    .value(ev_val)
  );

  // configuration port
  assign pready = 1'b1;
  assign prdata = 32'(domain_r);
  assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);

  // effective domain minus one
  always_comb begin
    if (domain_r == '0) begin
      nm1 = '0;
    end else if (domain_r > lcmt_pkg::DOM_W'(lcmt_pkg::MAX_POINTS)) begin
      nm1 = XW'(lcmt_pkg::MAX_POINTS - 1);
    end else begin
      nm1 = XW'(domain_r - 1'b1);
    end
  end

  assign hi_clamp = (in_seg_hi > nm1) ? nm1 : in_seg_hi;
  assign in_stall = (state_r != lcmt_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign lr_sum  = (XW+1)'(l_r) + (XW+1)'(r_r);
  assign mid     = lr_sum[XW:1];
  assign i_left  = NW'({i_r, 1'b1});
  assign i_right = NW'({i_r, 1'b0}) + NW'(2);
  assign i_oob   = (i_r >= NW'(lcmt_pkg::NODE_COUNT));

  assign rd_valid = ram_rdata[LW-1];
  assign rd_slope = ram_rdata[SW+BW-1:BW];
  assign rd_icpt  = ram_rdata[BW-1:0];

  // res_r: 0 cur at l, 1 cur at r, 2 new at l, 3 new at r, 4 cur at mid, 5 new at mid
  assign keep     = (res_r[0] >= res_r[2]) && (res_r[1] >= res_r[3]);
  assign repl     = (res_r[0] <= res_r[2]) && (res_r[1] <= res_r[3]);
  assign swapped  = res_r[5] > res_r[4];
  assign go_right = (!swapped && (res_r[3] > res_r[1])) || (swapped && (res_r[3] < res_r[1]));

  assign cvis_skip = (lo_r > r_r) || (hi_r < l_r) || i_oob;
  assign cvis_full = (lo_r <= l_r) && (r_r <= hi_r);
  assign drd_skip  = (l_r > r_r) || i_oob;

  assign top_ent  = stk_r[STK_IDX'(sp_r - 1'b1)];

  // evaluator operand select
  always_comb begin
    ev_k = k_r;
    ev_b = b_r;
    ev_x = x_r;
    if (state_r == lcmt_pkg::S_QEV) begin
      ev_k = rd_slope;
      ev_b = rd_icpt;
    end else begin
      case (step_r)
        3'd0: begin ev_k = rd_slope; ev_b = rd_icpt; ev_x = l_r; end
        3'd1: begin ev_k = rd_slope; ev_b = rd_icpt; ev_x = r_r; end
        3'd2: begin ev_x = l_r; end
        3'd3: begin ev_x = r_r; end
        3'd4: begin ev_k = rd_slope; ev_b = rd_icpt; ev_x = mid; end
        default: begin ev_x = mid; end
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lcmt_pkg::S_CLR: begin
        if (clr_r == '1) state_nxt = lcmt_pkg::S_IDLE;
      end
      lcmt_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (lcmt_pkg::op_t'(in_op))
            lcmt_pkg::OP_FULL:  state_nxt = lcmt_pkg::S_DRD;
            lcmt_pkg::OP_SEG:   state_nxt = (in_seg_lo <= hi_clamp) ? lcmt_pkg::S_CVIS
                                                                    : lcmt_pkg::S_IDLE;
            lcmt_pkg::OP_QUERY: state_nxt = (in_query_x > nm1) ? lcmt_pkg::S_QOUT
                                                               : lcmt_pkg::S_QRD;
            default:            state_nxt = lcmt_pkg::S_IDLE;
          endcase
        end
      end
      lcmt_pkg::S_DRD:  state_nxt = drd_skip ? lcmt_pkg::S_NEXT : lcmt_pkg::S_DEV;
      lcmt_pkg::S_DEV: begin
        if (step_r == 3'd0 && !rd_valid) state_nxt = lcmt_pkg::S_NEXT;
        else if (step_r == 3'd6)         state_nxt = lcmt_pkg::S_DDEC;
      end
      lcmt_pkg::S_DDEC: state_nxt = (keep || repl) ? lcmt_pkg::S_NEXT : lcmt_pkg::S_DRD;
      lcmt_pkg::S_NEXT: state_nxt = (sp_r == '0) ? lcmt_pkg::S_IDLE : lcmt_pkg::S_CVIS;
      lcmt_pkg::S_CVIS: begin
        if (cvis_skip)      state_nxt = lcmt_pkg::S_NEXT;
        else if (cvis_full) state_nxt = lcmt_pkg::S_DRD;
      end
      lcmt_pkg::S_QRD:  state_nxt = i_oob ? lcmt_pkg::S_QOUT : lcmt_pkg::S_QEV;
      lcmt_pkg::S_QEV:  state_nxt = lcmt_pkg::S_QACC;
      lcmt_pkg::S_QACC: state_nxt = (l_r == r_r) ? lcmt_pkg::S_QOUT : lcmt_pkg::S_QRD;
      lcmt_pkg::S_QOUT: begin
        if (!out_valid_r || !out_stall) state_nxt = lcmt_pkg::S_IDLE;
      end
      default: state_nxt = lcmt_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    k_nxt     = k_r;
    b_nxt     = b_r;
    ks_nxt    = ks_r;
    bs_nxt    = bs_r;
    x_nxt     = x_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    i_nxt     = i_r;
    l_nxt     = l_r;
    r_nxt     = r_r;
    step_nxt  = step_r;
    best_nxt  = best_r;
    found_nxt = found_r;
    clr_nxt   = clr_r;
    sp_nxt    = sp_r;
    push      = 1'b0;
    pop       = 1'b0;
    push_ent  = '{idx: i_right, lo: XW'(mid + 1'b1), hi: r_r};
    res_we    = 1'b0;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = i_r[AW-1:0];
    ram_wdata = {1'b1, k_r, b_r};
    unique case (state_r)
      lcmt_pkg::S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
      end
      lcmt_pkg::S_IDLE: begin
        if (in_acc) begin
          k_nxt     = in_slope;
          b_nxt     = in_intercept;
          ks_nxt    = in_slope;
          bs_nxt    = in_intercept;
          x_nxt     = in_query_x;
          lo_nxt    = in_seg_lo;
          hi_nxt    = hi_clamp;
          i_nxt     = '0;
          l_nxt     = '0;
          r_nxt     = nm1;
          sp_nxt    = '0;
          best_nxt  = '0;
          found_nxt = 1'b0;
        end
      end
      lcmt_pkg::S_DRD: begin
        step_nxt = '0;
        ram_re   = !drd_skip;
      end
      lcmt_pkg::S_DEV: begin
        if (step_r == 3'd0 && !rd_valid) begin
          ram_we = 1'b1;
        end else begin
          step_nxt = step_r + 1'b1;
          res_we   = (step_r != 3'd0);
        end
      end
      lcmt_pkg::S_DDEC: begin
        if (repl && !keep) begin
          ram_we = 1'b1;
        end else if (!keep) begin
          if (swapped) begin
            ram_we = 1'b1;
            k_nxt  = rd_slope;
            b_nxt  = rd_icpt;
          end
          if (go_right) begin
            l_nxt = XW'(mid + 1'b1);
            i_nxt = i_right;
          end else begin
            r_nxt = mid;
            i_nxt = i_left;
          end
        end
      end
      lcmt_pkg::S_NEXT: begin
        if (sp_r != '0) begin
          pop    = 1'b1;
          sp_nxt = sp_r - 1'b1;
          i_nxt  = top_ent.idx;
          l_nxt  = top_ent.lo;
          r_nxt  = top_ent.hi;
          k_nxt  = ks_r;
          b_nxt  = bs_r;
        end
      end
      lcmt_pkg::S_CVIS: begin
        if (!cvis_skip && !cvis_full) begin
          push   = 1'b1;
          sp_nxt = sp_r + 1'b1;
          i_nxt  = i_left;
          r_nxt  = mid;
        end
      end
      lcmt_pkg::S_QRD: begin
        ram_re = !i_oob;
      end
      lcmt_pkg::S_QEV: begin
      end
      lcmt_pkg::S_QACC: begin
        if (rd_valid) begin
          found_nxt = 1'b1;
          if (!found_r || ev_val > best_r) best_nxt = ev_val;
        end
        if (l_r != r_r) begin
          if (x_r <= mid) begin
            r_nxt = mid;
            i_nxt = i_left;
          end else begin
            l_nxt = XW'(mid + 1'b1);
            i_nxt = i_right;
          end
        end
      end
      lcmt_pkg::S_QOUT: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcmt_pkg::S_CLR;
      clr_r       <= '0;
      sp_r        <= '0;
      step_r      <= '0;
      domain_r    <= lcmt_pkg::DOM_W'(lcmt_pkg::MAX_POINTS);
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      sp_r     <= sp_nxt;
      step_r   <= step_nxt;
      if (cfg_wr) domain_r <= pwdata[lcmt_pkg::DOM_W-1:0];
      if (out_load)                     out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    b_r     <= b_nxt;
    ks_r    <= ks_nxt;
    bs_r    <= bs_nxt;
    x_r     <= x_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    i_r     <= i_nxt;
    l_r     <= l_nxt;
    r_r     <= r_nxt;
    best_r  <= best_nxt;
    found_r <= found_nxt;
    if (push) stk_r[sp_r[STK_IDX-1:0]] <= push_ent;
    if (res_we) res_r[3'(step_r - 3'd1)] <= ev_val;
    if (out_load) begin
      out_value_r <= found_r ? best_r : '0;
      out_found_r <= found_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_max_value = out_value_r;
  assign out_found     = out_found_r;

  // the store is never written outside an operation or the clearing pass
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r != lcmt_pkg::S_IDLE && state_r != lcmt_pkg::S_QOUT))
    else $error("node store written while idle");

  // no item taken during the clearing pass
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lcmt_pkg::S_CLR) |-> in_stall)
    else $error("item accepted during clear");

  // split stack depth stays within the tree height
  assert property (@(posedge clk) disable iff (!rst_n)
    (sp_r <= (lcmt_pkg::STK_W+1)'(12)) && !(pop && push))
    else $error("split stack overflow");

endmodule
`default_nettype wire

@@ rtl/lcmt_ram.sv @@
// generic single write port, single read port ram with registered read
`default_nettype none
module lcmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/lcmt_eval.sv @@
// shared line evaluator: slope*x+intercept, registered result
`default_nettype none
module lcmt_eval (
  input  wire logic                                clk,
  input  wire logic signed [lcmt_pkg::SLOPE_W-1:0] slope,
  input  wire logic signed [lcmt_pkg::ICPT_W-1:0]  icpt,
  input  wire logic [lcmt_pkg::X_W-1:0]            x,
  output logic signed [lcmt_pkg::VAL_W-1:0]        value
);

  localparam int PROD_W = lcmt_pkg::SLOPE_W + lcmt_pkg::X_W + 1;

  logic signed [PROD_W-1:0]           prod;
  logic signed [lcmt_pkg::VAL_W-1:0]  sum;

  assign prod = slope * $signed({1'b0, x});
  assign sum  = lcmt_pkg::VAL_W'(prod) + lcmt_pkg::VAL_W'(icpt);

  always_ff @(posedge clk) begin
    value <= sum;
  end

endmodule
`default_nettype wire
